FILE: design/clns_pkg.sv
// shared types, codes and phase tables for the 4-bit character lcd sequencer
// no dependencies
package clns_pkg;

  localparam int PulseW   = 10;
  localparam int ExecW    = 14;
  localparam int ClearW   = 17;
  localparam int PowerupW = 20;
  localparam int HoldW    = 21;
  localparam int CfgDataW = 20;
  localparam int StepW    = 5;

  localparam logic [HoldW-1:0] WaitFirstUs = HoldW'(5000);
  localparam logic [HoldW-1:0] WaitNextUs  = HoldW'(150);

  localparam logic [7:0] CursorRow0 = 8'h80;
  localparam logic [7:0] CursorRow1 = 8'hC0;
  localparam logic [7:0] FnSet4Bit  = 8'h28;
  localparam logic [7:0] DisplayOff = 8'h08;
  localparam logic [7:0] ClearCmd   = 8'h01;
  localparam logic [7:0] EntryMode  = 8'h06;
  localparam logic [7:0] DisplayOn  = 8'h0C;
  localparam logic [3:0] WakeNibble = 4'h3;
  localparam logic [3:0] Mode4Nib   = 4'h2;

  localparam logic [StepW-1:0] InitLastStep  = StepW'(28);
  localparam logic [StepW-1:0] InitByteStart = StepW'(9);

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_CURSOR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PULSE   = 2'd0,
    REG_EXEC    = 2'd1,
    REG_CLEAR   = 2'd2,
    REG_POWERUP = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    HOLD_PULSE,
    HOLD_POWERUP,
    HOLD_WAIT_FIRST,
    HOLD_WAIT_NEXT,
    HOLD_EXEC,
    HOLD_CLEAR
  } hold_sel_t;

  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] value;
    logic       clr;
  } entry_t;

  typedef struct packed {
    logic      en;
    logic [3:0] nib;
    hold_sel_t hold_sel;
  } phase_t;

  typedef struct packed {
    logic [PulseW-1:0]   pulse_us;
    logic [ExecW-1:0]    exec_us;
    logic [ClearW-1:0]   clear_us;
    logic [PowerupW-1:0] powerup_us;
  } cfg_t;

  function automatic phase_t byte_phase(input logic [7:0] value, input logic [1:0] sub,
                                        input logic clr);
    phase_t p;
    p.en       = ~sub[0];
    p.nib      = sub[1] ? value[3:0] : value[7:4];
    p.hold_sel = (sub == 2'd3) ? (clr ? HOLD_CLEAR : HOLD_EXEC) : HOLD_PULSE;
    return p;
  endfunction

  function automatic phase_t init_phase(input logic [StepW-1:0] idx);
    phase_t           p;
    logic [StepW-1:0] k;
    logic [StepW-1:0] j;
    logic [7:0]       b;
    k = idx - StepW'(1);
    j = idx - InitByteStart;
    case (j[4:2])
      3'd0:    b = FnSet4Bit;
      3'd1:    b = DisplayOff;
      3'd2:    b = ClearCmd;
      3'd3:    b = EntryMode;
      default: b = DisplayOn;
    endcase
    if (idx == '0) begin
      p.en       = 1'b0;
      p.nib      = 4'h0;
      p.hold_sel = HOLD_POWERUP;
    end else if (idx < InitByteStart) begin
      p.en  = ~k[0];
      p.nib = (k[2:1] == 2'd3) ? Mode4Nib : WakeNibble;
      if (!k[0]) p.hold_sel = HOLD_PULSE;
      else if (k == StepW'(1)) p.hold_sel = HOLD_WAIT_FIRST;
      else p.hold_sel = HOLD_WAIT_NEXT;
    end else begin
      p = byte_phase(b, j[1:0], j[4:2] == 3'd2);
    end
    return p;
  endfunction

endpackage

FILE: design/clns_front.sv
// request classifier: turns a request into a byte or init queue entry
// depends on clns_pkg
module clns_front (
  input  logic [1:0]      cmd,
  input  logic [7:0]      byte_value,
  input  logic            is_data,
  input  logic            row,
  input  logic [5:0]      col,
  output clns_pkg::entry_t entry
);
  import clns_pkg::*;

  always_comb begin
    entry.init  = 1'b0;
    entry.rs    = 1'b0;
    entry.value = byte_value;
    entry.clr   = 1'b0;
    case (cmd_t'(cmd))
      CMD_INIT:   entry.init = 1'b1;
      CMD_WRITE:  entry.rs = is_data;
      CMD_CLEAR: begin
        entry.value = ClearCmd;
        entry.clr   = 1'b1;
      end
      CMD_CURSOR: entry.value = (row ? CursorRow1 : CursorRow0) + {2'b00, col};
      default:    entry.init = 1'b0;
    endcase
  end

endmodule

FILE: design/clns_queue.sv
// two-entry request queue between classifier and phase sequencer
// depends on clns_pkg
module clns_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clns_pkg::entry_t push_entry,
  input  logic             pop,
  output clns_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import clns_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/clns_back.sv
// phase sequencer: expands the queue head into pin phases, one per cycle while the queue is not empty
// depends on clns_pkg
module clns_back (
  input  logic                     clk,
  input  logic                     rst,
  input  clns_pkg::entry_t         head,
  input  logic                     empty,
  input  clns_pkg::cfg_t           cfg,
  output logic                     pop,
  output logic                     strobe,
  output logic                     rs_pin,
  output logic                     en_pin,
  output logic [3:0]               data_nibble,
  output logic [clns_pkg::HoldW-1:0] hold_us,
  output logic                     last
);
  import clns_pkg::*;

  logic [StepW-1:0] step;
  phase_t           ph;
  logic             is_last;
  logic [HoldW-1:0] hold_next;
  logic [HoldW-1:0] pulse_ext;

  always_comb begin
    if (head.init) begin
      ph      = init_phase(step);
      is_last = (step == InitLastStep);
    end else begin
      ph      = byte_phase(head.value, step[1:0], head.clr);
      is_last = (step[1:0] == 2'd3);
    end
  end

  assign pop       = ~empty & is_last;
  assign pulse_ext = HoldW'(cfg.pulse_us);

  always_comb begin
    case (ph.hold_sel)
      HOLD_PULSE:      hold_next = pulse_ext;
      HOLD_POWERUP:    hold_next = HoldW'(cfg.powerup_us);
      HOLD_WAIT_FIRST: hold_next = pulse_ext + WaitFirstUs;
      HOLD_WAIT_NEXT:  hold_next = pulse_ext + WaitNextUs;
      HOLD_EXEC:       hold_next = pulse_ext + HoldW'(cfg.exec_us);
      HOLD_CLEAR:      hold_next = pulse_ext + HoldW'(cfg.exec_us) + HoldW'(cfg.clear_us);
      default:         hold_next = pulse_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= ~empty;
      if (!empty) step <= is_last ? '0 : step + StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rs_pin      <= head.rs;
    en_pin      <= ph.en;
    data_nibble <= ph.nib;
    hold_us     <= hold_next;
    last        <= is_last;
  end

endmodule

FILE: design/char_lcd_nibble_sequencer_top.sv
// 4-bit character lcd sequencer: classifier, two-entry queue, phase sequencer
// start writes the queue and each phase is registered at the outputs; then one phase per
// cycle while the queue is not empty, 4 phases per byte request and 29 per init, so byte
// requests run back to back; busy is high while the two-entry queue is full; results cannot be stalled
// synchronous reset empties the queue and loads the register defaults
// depends on clns_pkg, clns_front, clns_queue, clns_back
module char_lcd_nibble_sequencer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [7:0]                  byte_value,
  input  logic                        is_data,
  input  logic                        row,
  input  logic [5:0]                  col,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [clns_pkg::CfgDataW-1:0] cfg_data,
  output logic                        strobe,
  output logic                        rs_pin,
  output logic                        en_pin,
  output logic [3:0]                  data_nibble,
  output logic [clns_pkg::HoldW-1:0]  hold_us,
  output logic                        last
);
  import clns_pkg::*;

  cfg_t   cfg;
  entry_t entry;
  entry_t head;
  logic   empty;
  logic   full;
  logic   pop;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_us   <= PulseW'(50);
      cfg.exec_us    <= ExecW'(200);
      cfg.clear_us   <= ClearW'(2000);
      cfg.powerup_us <= PowerupW'(100000);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PULSE:   cfg.pulse_us   <= cfg_data[PulseW-1:0];
        REG_EXEC:    cfg.exec_us    <= cfg_data[ExecW-1:0];
        REG_CLEAR:   cfg.clear_us   <= cfg_data[ClearW-1:0];
        REG_POWERUP: cfg.powerup_us <= cfg_data[PowerupW-1:0];
        default:     cfg.pulse_us   <= cfg.pulse_us;
      endcase
    end
  end

  clns_front u_front (
    .cmd        (cmd),
    .byte_value (byte_value),
    .is_data    (is_data),
    .row        (row),
    .col        (col),
    .entry      (entry)
  );

  clns_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (start & ~full),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  clns_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .cfg         (cfg),
    .pop         (pop),
    .strobe      (strobe),
    .rs_pin      (rs_pin),
    .en_pin      (en_pin),
    .data_nibble (data_nibble),
    .hold_us     (hold_us),
    .last        (last)
  );

endmodule

FILE: test/char_lcd_nibble_sequencer_top_test.sv
// self-checking testbench for the 4-bit character lcd sequencer: directed table, then random
// requests against a predictor of the pin phases, across several register settings
// depends on clns_pkg and char_lcd_nibble_sequencer_top
module char_lcd_nibble_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clns_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 8;
  localparam int RandPerSet  = 85;
  localparam int NumSettings = 6;

  typedef struct {
    logic             rs;
    logic             en;
    logic [3:0]       nib;
    logic [HoldW-1:0] hold;
    logic             last;
  } lcd_phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] byte_value;
    logic       is_data;
    logic       row;
    logic [5:0] col;
    logic       typed;
    logic       trs;
    logic [7:0] tbyte;
  } dir_row_t;

  localparam int NumRows = 15;
  localparam dir_row_t DirRows [NumRows] = '{
    '{CMD_INIT,   8'h00, 1'b0, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00},
    '{CMD_INIT,   8'hFF, 1'b1, 1'b1, 6'd63, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE,  8'h00, 1'b0, 1'b0, 6'd0,  1'b1, 1'b0, 8'h00},
    '{CMD_WRITE,  8'hFF, 1'b1, 1'b0, 6'd0,  1'b1, 1'b1, 8'hFF},
    '{CMD_WRITE,  8'hA5, 1'b1, 1'b1, 6'd63, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE,  8'h5A, 1'b0, 1'b0, 6'd21, 1'b0, 1'b0, 8'h00},
    '{CMD_CLEAR,  8'h00, 1'b0, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00},
    '{CMD_CLEAR,  8'hFF, 1'b1, 1'b1, 6'd63, 1'b0, 1'b0, 8'h00},
    '{CMD_CURSOR, 8'h00, 1'b0, 1'b0, 6'd0,  1'b1, 1'b0, 8'h80},
    '{CMD_CURSOR, 8'h00, 1'b0, 1'b1, 6'd0,  1'b1, 1'b0, 8'hC0},
    '{CMD_CURSOR, 8'h00, 1'b0, 1'b0, 6'd39, 1'b1, 1'b0, 8'hA7},
    '{CMD_CURSOR, 8'hFF, 1'b1, 1'b1, 6'd39, 1'b1, 1'b0, 8'hE7},
    '{CMD_CURSOR, 8'h00, 1'b0, 1'b0, 6'd63, 1'b1, 1'b0, 8'hBF},
    '{CMD_CURSOR, 8'h00, 1'b0, 1'b1, 6'd63, 1'b1, 1'b0, 8'hFF},
    '{CMD_CURSOR, 8'hFF, 1'b1, 1'b1, 6'd17, 1'b0, 1'b0, 8'h00}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          cmd = '0;
  logic [7:0]          byte_value = '0;
  logic                is_data = 1'b0;
  logic                row = 1'b0;
  logic [5:0]          col = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                strobe;
  logic                rs_pin;
  logic                en_pin;
  logic [3:0]          data_nibble;
  logic [HoldW-1:0]    hold_us;
  logic                last;

  logic [PulseW-1:0]   cur_pulse;
  logic [ExecW-1:0]    cur_exec;
  logic [ClearW-1:0]   cur_clear;
  logic [PowerupW-1:0] cur_powerup;

  lcd_phase_t pending_phases[$];
  int         failures = 0;
  int         stall_count = 0;
  bit         burst_mode = 1'b0;

  char_lcd_nibble_sequencer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .byte_value(byte_value), .is_data(is_data), .row(row), .col(col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .strobe(strobe), .rs_pin(rs_pin), .en_pin(en_pin), .data_nibble(data_nibble),
    .hold_us(hold_us), .last(last)
  );

  always #1 clk = ~clk;

  task automatic note_failure(string msg);
    $display("ERROR: %s", msg);
    failures++;
  endtask

  task automatic push_phase(logic rs, logic en, logic [3:0] nib, int hold);
    lcd_phase_t p;
    p.rs   = rs;
    p.en   = en;
    p.nib  = nib;
    p.hold = HoldW'(hold);
    p.last = 1'b0;
    pending_phases.push_back(p);
  endtask

  task automatic push_nibble(logic rs, logic [3:0] nib, int extra);
    push_phase(rs, 1'b1, nib, int'(cur_pulse));
    push_phase(rs, 1'b0, nib, int'(cur_pulse) + extra);
  endtask

  task automatic push_byte(logic rs, logic [7:0] val, int extra);
    push_nibble(rs, val[7:4], 0);
    push_nibble(rs, val[3:0], int'(cur_exec) + extra);
  endtask

  task automatic expand_request(cmd_t c, logic [7:0] bv, logic d, logic r, logic [5:0] cl);
    case (c)
      CMD_INIT: begin
        push_phase(1'b0, 1'b0, 4'h0, int'(cur_powerup));
        push_nibble(1'b0, WakeNibble, int'(WaitFirstUs));
        push_nibble(1'b0, WakeNibble, int'(WaitNextUs));
        push_nibble(1'b0, WakeNibble, int'(WaitNextUs));
        push_nibble(1'b0, Mode4Nib, int'(WaitNextUs));
        push_byte(1'b0, FnSet4Bit, 0);
        push_byte(1'b0, DisplayOff, 0);
        push_byte(1'b0, ClearCmd, int'(cur_clear));
        push_byte(1'b0, EntryMode, 0);
        push_byte(1'b0, DisplayOn, 0);
      end
      CMD_WRITE: push_byte(d, bv, 0);
      CMD_CLEAR: push_byte(1'b0, ClearCmd, int'(cur_clear));
      default: push_byte(1'b0, (r ? CursorRow1 : CursorRow0) + {2'b00, cl}, 0);
    endcase
  endtask

  task automatic issue_request(dir_row_t q);
    start      <= 1'b1;
    cmd        <= q.cmd;
    byte_value <= q.byte_value;
    is_data    <= q.is_data;
    row        <= q.row;
    col        <= q.col;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (q.typed) push_byte(q.trs, q.tbyte, 0);
    else expand_request(q.cmd, q.byte_value, q.is_data, q.row, q.col);
    pending_phases[pending_phases.size()-1].last = 1'b1;
  endtask

  task automatic pace();
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 55) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_config(logic [CfgDataW-1:0] vals [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (reg_idx_t'(i))
        REG_PULSE:   cur_pulse   = vals[i][PulseW-1:0];
        REG_EXEC:    cur_exec    = vals[i][ExecW-1:0];
        REG_CLEAR:   cur_clear   = vals[i][ClearW-1:0];
        default:     cur_powerup = vals[i][PowerupW-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic dir_row_t random_request();
    dir_row_t q;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) q.cmd = CMD_INIT;
    else if (roll < 60) q.cmd = CMD_WRITE;
    else if (roll < 72) q.cmd = CMD_CLEAR;
    else q.cmd = CMD_CURSOR;
    q.byte_value = 8'($urandom);
    q.is_data    = 1'($urandom);
    q.row        = 1'($urandom);
    q.col        = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 39))
                                               : 6'($urandom_range(0, 63));
    q.typed      = 1'b0;
    q.trs        = 1'b0;
    q.tbyte      = 8'h00;
    return q;
  endfunction

  // result checker
  always @(posedge clk) begin
    lcd_phase_t want;
    if (!rst && strobe) begin
      if (pending_phases.size() == 0) begin
        note_failure($sformatf("phase with no request pending: rs %0b en %0b nib %h hold %0d",
                               rs_pin, en_pin, data_nibble, hold_us));
      end else begin
        want = pending_phases.pop_front();
        if (rs_pin !== want.rs)
          note_failure($sformatf("rs_pin got %b want %b", rs_pin, want.rs));
        if (en_pin !== want.en)
          note_failure($sformatf("en_pin got %b want %b", en_pin, want.en));
        if (data_nibble !== want.nib)
          note_failure($sformatf("data_nibble got %h want %h", data_nibble, want.nib));
        if (hold_us !== want.hold)
          note_failure($sformatf("hold_us got %0d want %0d", hold_us, want.hold));
        if (last !== want.last)
          note_failure($sformatf("last got %b want %b", last, want.last));
      end
    end
  end

  // watchdog on cycles without any accepted request, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CfgDataW-1:0] vals [4];
    cur_pulse   = PulseW'(50);
    cur_exec    = ExecW'(200);
    cur_clear   = ClearW'(2000);
    cur_powerup = PowerupW'(100000);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    for (int s = 0; s < NumSettings; s++) begin
      if (s > 0) begin
        wait_idle();
        case (s)
          1: vals = '{20'd1, 20'd0, 20'd0, 20'd0};
          2: vals = '{20'd1000, 20'd10000, 20'd100000, 20'd1000000};
          3: vals = '{20'h003FF, 20'h03FFF, 20'h1FFFF, 20'hFFFFF};
          4: vals = '{20'd0, 20'($urandom_range(0, 10000)), 20'($urandom_range(0, 100000)),
                      20'($urandom_range(0, 1000000))};
          default: vals = '{20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom)};
        endcase
        load_config(vals);
      end
      if (s == 0 || s == 1 || s == 3) begin
        for (int i = 0; i < NumRows; i++) begin
          issue_request(DirRows[i]);
          pace();
        end
      end
      for (int i = 0; i < RandPerSet; i++) begin
        if (i % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        issue_request(random_request());
        pace();
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end

    wait_idle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
